// ===== rtl/core/a85_pkg.sv =====
// a85_pkg: shared types and constants of the ascii85 codec
// payload structs, front-to-back job format, character codes
// no dependencies
`default_nettype none

package a85_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_end;
    logic       error;
  } out_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_ZMARK = 3'd1,
    OP_CHARS = 3'd2,
    OP_BYTES = 3'd3,
    OP_PAD   = 3'd4,
    OP_ERR   = 3'd5
  } op_e;

  // one classified item for the back end
  typedef struct packed {
    logic        lead_err;
    op_e         op;
    logic [31:0] value;
    logic [2:0]  count;
    logic        err;
    logic        eos;
  } job_t;

  // results of one job, ready to stream out
  typedef struct packed {
    logic [4:0][7:0] data;
    logic [4:0]      err;
    logic [2:0]      n;
    logic            eos;
  } burst_t;

  localparam logic [7:0]  DIGIT_BASE  = 8'd33;
  localparam logic [7:0]  LAST_DIGIT  = 8'd117;
  localparam logic [7:0]  ZERO_MARK   = 8'd122;
  localparam logic [31:0] RECIP_85    = 32'd3233857729;
  localparam int unsigned RECIP_SHIFT = 38;

  // 85^(5-k) for a partial decode group of k digits
  function automatic logic [19:0] pad_scale(input logic [2:0] k);
    logic [19:0] s;
    case (k)
      3'd2:    s = 20'd614125;
      3'd3:    s = 20'd7225;
      default: s = 20'd85;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ascii85_codec_unit.sv =====
// ascii85_codec_unit: streaming ascii85 encoder/decoder, top level
// instantiates a85_front, a85_fifo, a85_back; depends on a85_pkg
//
// Bytes or characters enter one per cycle through push/full; results leave
// through empty/pop from an output register, one per cycle. cfg_we_i writes
// the direction (0 encode, 1 decode) and clears any partial group; write it
// only while the block is drained. Decoding, every character is classified
// as it is accepted and a group's four bytes stream out one per cycle while
// pop is high. Encoding, a full group goes through a divide-by-85 unit that
// yields one digit per step, two in the last, while the previous group's five
// characters stream out, so the output port, not the divider, sets the
// sustained rate. A decode flush of a partial group adds a multiply step. No
// clearing pass after reset. The job queue between classifier and converter
// holds JobDepth entries.
`default_nettype none

module ascii85_codec_unit #(
  parameter int unsigned JobDepth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           push,
  input  a85_pkg::in_t   in_data_i,
  output logic           full,
  input  logic           pop,
  output a85_pkg::out_t  out_data_o,
  output logic           empty
);

  logic          accept;
  logic          job_valid;
  a85_pkg::job_t job;
  logic          jq_full;
  logic          jq_empty;
  logic          jq_pop;
  a85_pkg::job_t jq_data;

  assign accept = push && !jq_full;
  assign full   = jq_full;

  a85_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (accept),
    .item_i       (in_data_i),
    .job_valid_o  (job_valid),
    .job_o        (job)
  );

  a85_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job),
    .full_o  (jq_full),
    .pop_i   (jq_pop),
    .data_o  (jq_data),
    .empty_o (jq_empty)
  );

  a85_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!jq_empty),
    .job_i       (jq_data),
    .job_pop_o   (jq_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/a85_front.sv =====
// a85_front: accepts items, keeps the group state, classifies into jobs
// depends on a85_pkg
`default_nettype none

module a85_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            item_valid_i,
  input  a85_pkg::in_t    item_i,
  output logic            job_valid_o,
  output a85_pkg::job_t   job_o
);

  logic        dir_q, dir_d;
  logic [31:0] gv_q, gv_d;
  logic [2:0]  gc_q, gc_d;
  logic        ovf_q, ovf_d;

  logic [31:0] enc_val;
  logic [2:0]  enc_cnt;
  logic [7:0]  chr;
  logic        eos;
  logic        dig_ok;
  logic        is_zmark;
  logic [6:0]  digit;
  logic [38:0] acc;
  logic        acc_ovf;
  logic [31:0] dv;
  logic [2:0]  dc;
  logic        dovf;
  a85_pkg::job_t job;

  always_comb begin
    enc_val  = {gv_q[23:0], item_i.in_byte};
    enc_cnt  = gc_q + 3'd1;
    chr      = item_i.in_byte;
    eos      = item_i.end_of_stream;
    dig_ok   = (chr >= a85_pkg::DIGIT_BASE) && (chr <= a85_pkg::LAST_DIGIT);
    is_zmark = (chr == a85_pkg::ZERO_MARK) && (gc_q == 3'd0);
    digit    = 7'(chr - a85_pkg::DIGIT_BASE);
    acc      = 39'(gv_q) * 39'd85 + 39'(digit);
    acc_ovf  = |acc[38:32];
  end

  always_comb begin
    dir_d = dir_q;
    gv_d  = gv_q;
    gc_d  = gc_q;
    ovf_d = ovf_q;
    dv    = gv_q;
    dc    = gc_q;
    dovf  = ovf_q;
    job   = '0;
    job.eos = eos;
    job_valid_o = 1'b0;
    if (item_valid_i) begin
      if (!dir_q) begin
        if (enc_cnt == 3'd4) begin
          job_valid_o = 1'b1;
          job.op    = (enc_val == 32'd0) ? a85_pkg::OP_ZMARK : a85_pkg::OP_CHARS;
          job.value = enc_val;
          job.count = 3'd5;
          gv_d  = '0;
          gc_d  = '0;
          ovf_d = 1'b0;
        end else if (eos) begin
          job_valid_o = 1'b1;
          job.op    = a85_pkg::OP_CHARS;
          job.count = enc_cnt + 3'd1;
          case (enc_cnt)
            3'd1:    job.value = {enc_val[7:0], 24'd0};
            3'd2:    job.value = {enc_val[15:0], 16'd0};
            3'd3:    job.value = {enc_val[23:0], 8'd0};
            default: job.value = enc_val;
          endcase
          gv_d  = '0;
          gc_d  = '0;
          ovf_d = 1'b0;
        end else begin
          gv_d = enc_val;
          gc_d = enc_cnt;
        end
      end else begin
        if (is_zmark) begin
          job.op    = a85_pkg::OP_BYTES;
          job.value = '0;
          job.count = 3'd4;
        end else if (!dig_ok) begin
          job.lead_err = 1'b1;
        end else begin
          dv   = acc[31:0];
          dc   = gc_q + 3'd1;
          dovf = ovf_q | acc_ovf;
          if (dc == 3'd5) begin
            job.op    = a85_pkg::OP_BYTES;
            job.value = dv;
            job.count = 3'd4;
            job.err   = dovf;
            dv   = '0;
            dc   = '0;
            dovf = 1'b0;
          end
        end
        if (eos && (dc != 3'd0)) begin
          if (dc == 3'd1) begin
            job.op = a85_pkg::OP_ERR;
          end else begin
            job.op    = a85_pkg::OP_PAD;
            job.value = dv;
            job.count = dc;
            job.err   = dovf;
          end
        end
        if (eos) begin
          gv_d  = '0;
          gc_d  = '0;
          ovf_d = 1'b0;
        end else begin
          gv_d  = dv;
          gc_d  = dc;
          ovf_d = dovf;
        end
        job_valid_o = job.lead_err || (job.op != a85_pkg::OP_NONE);
      end
    end
    if (cfg_we_i) begin
      dir_d = cfg_wdata_i;
      gv_d  = '0;
      gc_d  = '0;
      ovf_d = 1'b0;
    end
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      gv_q  <= '0;
      gc_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      dir_q <= dir_d;
      gv_q  <= gv_d;
      gc_q  <= gc_d;
      ovf_q <= ovf_d;
    end
  end

  // group fill stays below a full group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gc_q <= 3'd3) || (dir_q && (gc_q == 3'd4)))
    else $error("group count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/a85_fifo.sv =====
// a85_fifo: short job queue between front and back
// depends on a85_pkg
`default_nettype none

module a85_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  a85_pkg::job_t   data_i,
  output logic            full_o,
  input  logic            pop_i,
  output a85_pkg::job_t   data_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  a85_pkg::job_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // back end only takes a job that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("job queue underflow");

endmodule

`default_nettype wire

// ===== rtl/core/a85_back.sv =====
// a85_back: converts jobs to result bursts and streams them out
// digit conversion by reciprocal multiply, one digit per step and two in the last; depends on a85_pkg
`default_nettype none

module a85_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  a85_pkg::job_t   job_i,
  output logic            job_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output a85_pkg::out_t   res_o
);

  logic            cv_busy_q, cv_busy_d;
  a85_pkg::job_t   cv_job_q;
  logic [1:0]      cv_step_q, cv_step_d;
  logic [31:0]     cv_num_q;
  logic [6:0]      dig_q [3];
  logic [52:0]     prod_q;

  logic            em_valid_q, em_valid_d;
  a85_pkg::burst_t em_q;
  logic [2:0]      em_idx_q, em_idx_d;

  logic            out_valid_q, out_valid_d;
  a85_pkg::out_t   out_q;

  logic [63:0]     div_prod;
  logic [25:0]     quo;
  logic [31:0]     rem_full;
  logic [6:0]      rem;
  logic            last_step;
  logic            advance;
  logic            finish;
  logic            em_last;
  logic            em_free;
  logic            out_load;
  logic [31:0]     pad_val;
  logic            pad_ovf;
  logic [4:0][7:0] m_data;
  logic [4:0]      m_err;
  logic [2:0]      m_n;
  a85_pkg::burst_t burst;

  // divide by 85
  always_comb begin
    div_prod = 64'(cv_num_q) * 64'(a85_pkg::RECIP_85);
    quo      = div_prod[63:a85_pkg::RECIP_SHIFT];
    rem_full = cv_num_q - 32'(quo) * 32'd85;
    rem      = rem_full[6:0];
  end

  always_comb begin
    case (cv_job_q.op)
      a85_pkg::OP_CHARS: last_step = (cv_step_q == 2'd3);
      a85_pkg::OP_PAD:   last_step = (cv_step_q == 2'd1);
      default:           last_step = 1'b1;
    endcase
  end

  assign em_last   = (em_idx_q == em_q.n - 3'd1);
  assign out_load  = em_valid_q && (!out_valid_q || pop_i);
  assign em_free   = !em_valid_q || (out_load && em_last);
  assign finish    = cv_busy_q && last_step && em_free;
  assign advance   = cv_busy_q && !last_step;
  assign job_pop_o = job_valid_i && (!cv_busy_q || finish);

  // padded decode group
  assign pad_val = prod_q[31:0] - 32'd1;
  assign pad_ovf = cv_job_q.err || (prod_q > 53'h1_0000_0000);

  always_comb begin
    m_data = '0;
    m_err  = '0;
    m_n    = '0;
    case (cv_job_q.op)
      a85_pkg::OP_ZMARK: begin
        m_data[0] = a85_pkg::ZERO_MARK;
        m_n       = 3'd1;
      end
      a85_pkg::OP_CHARS: begin
        m_data[0] = a85_pkg::DIGIT_BASE + {1'b0, quo[6:0]};
        m_data[1] = a85_pkg::DIGIT_BASE + {1'b0, rem};
        m_data[2] = a85_pkg::DIGIT_BASE + {1'b0, dig_q[2]};
        m_data[3] = a85_pkg::DIGIT_BASE + {1'b0, dig_q[1]};
        m_data[4] = a85_pkg::DIGIT_BASE + {1'b0, dig_q[0]};
        m_n       = cv_job_q.count;
      end
      a85_pkg::OP_BYTES: begin
        m_data[0] = cv_job_q.value[31:24];
        m_data[1] = cv_job_q.value[23:16];
        m_data[2] = cv_job_q.value[15:8];
        m_data[3] = cv_job_q.value[7:0];
        m_err     = {5{cv_job_q.err}};
        m_n       = cv_job_q.count;
      end
      a85_pkg::OP_PAD: begin
        m_data[0] = pad_val[31:24];
        m_data[1] = pad_val[23:16];
        m_data[2] = pad_val[15:8];
        m_data[3] = pad_val[7:0];
        m_err     = {5{pad_ovf}};
        m_n       = cv_job_q.count - 3'd1;
      end
      a85_pkg::OP_ERR: begin
        m_err[0] = 1'b1;
        m_n      = 3'd1;
      end
      default: begin
        m_n = '0;
      end
    endcase
  end

  always_comb begin
    burst     = '0;
    burst.eos = cv_job_q.eos;
    if (cv_job_q.lead_err) begin
      burst.err[0] = 1'b1;
      for (int j = 1; j < 5; j++) begin
        burst.data[j] = m_data[j-1];
        burst.err[j]  = m_err[j-1];
      end
      burst.n = m_n + 3'd1;
    end else begin
      burst.data = m_data;
      burst.err  = m_err;
      burst.n    = m_n;
    end
  end

  always_comb begin
    cv_busy_d = cv_busy_q;
    cv_step_d = cv_step_q;
    if (job_pop_o) begin
      cv_busy_d = 1'b1;
      cv_step_d = '0;
    end else if (finish) begin
      cv_busy_d = 1'b0;
    end else if (advance) begin
      cv_step_d = cv_step_q + 2'd1;
    end
  end

  always_comb begin
    em_valid_d = em_valid_q;
    em_idx_d   = em_idx_q;
    if (finish) begin
      em_valid_d = 1'b1;
      em_idx_d   = '0;
    end else if (out_load && em_last) begin
      em_valid_d = 1'b0;
    end else if (out_load) begin
      em_idx_d = em_idx_q + 3'd1;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_busy_q   <= 1'b0;
      cv_step_q   <= '0;
      em_valid_q  <= 1'b0;
      em_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cv_busy_q   <= cv_busy_d;
      cv_step_q   <= cv_step_d;
      em_valid_q  <= em_valid_d;
      em_idx_q    <= em_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cv_job_q <= job_i;
      cv_num_q <= job_i.value;
    end else if (advance) begin
      if (cv_job_q.op == a85_pkg::OP_CHARS) begin
        dig_q[cv_step_q] <= rem;
        cv_num_q         <= 32'(quo);
      end else begin
        prod_q <= 53'(33'(cv_job_q.value) + 33'd1) *
                  53'(a85_pkg::pad_scale(cv_job_q.count));
      end
    end
    if (finish) begin
      em_q <= burst;
    end
    if (out_load) begin
      out_q.out_byte    <= em_q.data[em_idx_q];
      out_q.last_of_run <= em_last;
      out_q.stream_end  <= em_last && em_q.eos;
      out_q.error       <= em_q.err[em_idx_q];
    end
  end

  assign empty_o = !out_valid_q;
  assign res_o   = out_q;

  // a held burst always has a result left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_valid_q |-> (em_q.n != 3'd0) && (em_idx_q < em_q.n))
    else $error("burst index past its length");

  // the front never queues a job without results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_busy_q |-> (cv_job_q.lead_err || (cv_job_q.op != a85_pkg::OP_NONE)))
    else $error("empty job in converter");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for the ascii85 codec unit
// directed rows, then random encode/decode phases, checked against a local predictor
// depends on a85_pkg and ascii85_codec_unit
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic          DIR_ENC     = 1'b0;
  localparam logic          DIR_DEC     = 1'b1;
  localparam int unsigned   PAD_DIGIT   = 84;
  localparam int unsigned   DRAIN_WAIT  = 40;
  localparam int unsigned   HOLD_CYCLES = 300;
  localparam int unsigned   STALL_LIMIT = 2000;
  localparam int unsigned   PHASES      = 6;
  localparam int unsigned   PHASE_ITEMS = 84;
  localparam int unsigned   ROWS        = 27;
  localparam a85_pkg::out_t NO_RES      = '0;

  typedef struct packed {
    logic          dir;
    logic [7:0]    b;
    logic          eos;
    logic          typed;
    a85_pkg::out_t res;
  } row_t;

  localparam row_t DIRECTED [ROWS] = '{
    '{DIR_ENC, 8'h00, 1'b0, 1'b0, NO_RES},
    '{DIR_ENC, 8'h00, 1'b0, 1'b0, NO_RES},
    '{DIR_ENC, 8'h00, 1'b0, 1'b0, NO_RES},
    '{DIR_ENC, 8'h00, 1'b0, 1'b1, '{a85_pkg::ZERO_MARK, 1'b1, 1'b0, 1'b0}},
    '{DIR_ENC, 8'hff, 1'b0, 1'b0, NO_RES},
    '{DIR_ENC, 8'hff, 1'b0, 1'b0, NO_RES},
    '{DIR_ENC, 8'hff, 1'b0, 1'b0, NO_RES},
    '{DIR_ENC, 8'hff, 1'b0, 1'b0, NO_RES},
    '{DIR_ENC, 8'h00, 1'b1, 1'b0, NO_RES},
    '{DIR_ENC, 8'hab, 1'b0, 1'b0, NO_RES},
    '{DIR_ENC, 8'hcd, 1'b1, 1'b0, NO_RES},
    '{DIR_DEC, "z",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, "s",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, "8",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, "W",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, "-",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, "!",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, "u",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, "u",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, "u",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, "u",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, "u",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
    '{DIR_DEC, "!",   1'b0, 1'b0, NO_RES},
    '{DIR_DEC, "z",   1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
    '{DIR_DEC, "u",   1'b1, 1'b0, NO_RES},
    '{DIR_DEC, "5",   1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}}
  };

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic          cfg_wdata_i;
  logic          push;
  a85_pkg::in_t  in_data_i;
  logic          full;
  logic          pop;
  a85_pkg::out_t out_data_o;
  logic          empty;

  // predictor state
  logic        dir_r;
  logic [31:0] acc_val;
  int unsigned acc_cnt;
  logic        acc_ovf;

  a85_pkg::out_t conv_q [$];
  a85_pkg::out_t owed_q [$];
  int unsigned items_sent;
  int unsigned err_cnt;
  int unsigned idle_cycles;
  bit          calm;
  bit          hold_req;

  ascii85_codec_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .in_data_i  (in_data_i),
    .full       (full),
    .pop        (pop),
    .out_data_o (out_data_o),
    .empty      (empty)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_group();
    acc_val = '0;
    acc_cnt = 0;
    acc_ovf = 1'b0;
  endfunction

  function automatic void put(logic [7:0] b, logic e);
    a85_pkg::out_t r;
    r = '{out_byte: b, last_of_run: 1'b0, stream_end: 1'b0, error: e};
    conv_q.insert(conv_q.size(), r);
  endfunction

  function automatic void put_digits(logic [31:0] v, int unsigned cnt);
    logic [7:0]  d [5];
    logic [31:0] w;
    w = v;
    for (int i = 4; i >= 0; i--) begin
      d[i] = 8'(w % 85);
      w = w / 85;
    end
    for (int i = 0; i < cnt; i++) put(a85_pkg::DIGIT_BASE + d[i], 1'b0);
  endfunction

  function automatic void put_bytes(logic [31:0] v, int unsigned cnt, logic e);
    for (int i = 0; i < cnt; i++) put(v[31-8*i -: 8], e);
  endfunction

  function automatic void add_digit(int unsigned d);
    logic [63:0] t;
    t = {32'd0, acc_val} * 64'd85 + 64'(d);
    if (t[63:32] != 0) acc_ovf = 1'b1;
    acc_val = t[31:0];
    acc_cnt++;
  endfunction

  // expected results of one accepted beat, left in conv_q
  function automatic void a85_convert(a85_pkg::in_t it);
    int unsigned k;
    conv_q.delete();
    if (dir_r == DIR_ENC) begin
      acc_val = {acc_val[23:0], it.in_byte};
      acc_cnt++;
      if (acc_cnt >= 4) begin
        if (acc_val == 0) put(a85_pkg::ZERO_MARK, 1'b0);
        else put_digits(acc_val, 5);
        clear_group();
      end else if (it.end_of_stream) begin
        put_digits(acc_val << (8 * (4 - acc_cnt)), acc_cnt + 1);
        clear_group();
      end
    end else begin
      if (it.in_byte == a85_pkg::ZERO_MARK && acc_cnt == 0) begin
        put_bytes('0, 4, 1'b0);
      end else if (it.in_byte < a85_pkg::DIGIT_BASE || it.in_byte > a85_pkg::LAST_DIGIT) begin
        put(8'h00, 1'b1);
      end else begin
        add_digit(int'(it.in_byte - a85_pkg::DIGIT_BASE));
        if (acc_cnt >= 5) begin
          put_bytes(acc_val, 4, acc_ovf);
          clear_group();
        end
      end
      if (it.end_of_stream && acc_cnt > 0) begin
        k = acc_cnt;
        if (k == 1) begin
          put(8'h00, 1'b1);
        end else begin
          while (acc_cnt < 5) add_digit(PAD_DIGIT);
          put_bytes(acc_val, k - 1, acc_ovf);
        end
      end
      if (it.end_of_stream) clear_group();
    end
    if (conv_q.size() > 0) begin
      conv_q[conv_q.size()-1].last_of_run = 1'b1;
      conv_q[conv_q.size()-1].stream_end  = it.end_of_stream;
    end
  endfunction

  task automatic send_item(logic [7:0] b, logic eos, logic typed, a85_pkg::out_t res);
    a85_pkg::in_t it;
    it = '{in_byte: b, end_of_stream: eos};
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= it;
    do @(negedge clk_i); while (full);
    @(posedge clk_i);
    items_sent++;
    a85_convert(it);
    if (typed) owed_q.insert(owed_q.size(), res);
    else foreach (conv_q[i]) owed_q.insert(owed_q.size(), conv_q[i]);
  endtask

  task automatic set_direction(logic d);
    push <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dir_r = d;
    clear_group();
  endtask

  task automatic encode_burst();
    int unsigned kind;
    int unsigned k;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      for (int i = 0; i < 4; i++)
        send_item(8'h00, i == 3 && $urandom_range(0, 3) == 0, 1'b0, NO_RES);
    end else if (kind == 1) begin
      k = $urandom_range(1, 3);
      for (int i = 0; i < k; i++)
        send_item(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), i == k - 1,
                  1'b0, NO_RES);
    end else begin
      for (int i = 0; i < 4; i++)
        send_item(8'($urandom), i == 3 && $urandom_range(0, 7) == 0, 1'b0, NO_RES);
    end
  endtask

  task automatic decode_burst();
    int unsigned kind;
    int unsigned k;
    logic [31:0] v;
    logic [7:0]  d [5];
    kind = $urandom_range(0, 15);
    if (kind < 2) begin
      send_item(a85_pkg::ZERO_MARK, $urandom_range(0, 5) == 0, 1'b0, NO_RES);
    end else if (kind < 4) begin
      send_item(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, NO_RES);
    end else if (kind < 6) begin
      k = $urandom_range(1, 4);
      for (int i = 0; i < k; i++)
        send_item(a85_pkg::DIGIT_BASE + 8'($urandom_range(0, 84)), i == k - 1,
                  1'b0, NO_RES);
    end else begin
      v = $urandom;
      for (int i = 4; i >= 0; i--) begin
        d[i] = (kind == 6) ? 8'($urandom_range(0, 84)) : 8'(v % 85);
        v = v / 85;
      end
      for (int i = 0; i < 5; i++)
        send_item(a85_pkg::DIGIT_BASE + d[i], i == 4 && $urandom_range(0, 7) == 0,
                  1'b0, NO_RES);
    end
  endtask

  // stimulus
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    push        = 1'b0;
    in_data_i   = '0;
    dir_r       = DIR_ENC;
    clear_group();
    items_sent  = 0;
    err_cnt     = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].dir != dir_r) set_direction(DIRECTED[i].dir);
      send_item(DIRECTED[i].b, DIRECTED[i].eos, DIRECTED[i].typed, DIRECTED[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      set_direction(ph[0] ? DIR_ENC : DIR_DEC);
      if (ph == 0) hold_req = 1'b1;
      if (ph == PHASES - 1) calm = 1'b1;
      while (items_sent < ROWS + (ph + 1) * PHASE_ITEMS) begin
        if (dir_r == DIR_ENC) encode_burst();
        else decode_burst();
      end
    end

    push <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: random stalls and one long hold
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    logic        pop_nx;
    stall_left = 0;
    hold_left  = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_nx = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop_nx = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        pop_nx = 1'b0;
      end else begin
        pop_nx = 1'b1;
      end
      pop <= pop_nx;
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // result checking and watchdog, sampled mid-cycle
  always @(negedge clk_i) begin
    a85_pkg::out_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result beat: out_byte %0h", out_data_o.out_byte);
          err_cnt++;
        end else begin
          want = owed_q.pop_front();
          check_field("out_byte", want.out_byte, out_data_o.out_byte);
          check_field("last_of_run", want.last_of_run, out_data_o.last_of_run);
          check_field("stream_end", want.stream_end, out_data_o.stream_end);
          check_field("error", want.error, out_data_o.error);
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule

`default_nettype wire
